// ===== src/cdp_tlv_frame_parser_core_macros.svh =====
// Assertion macros shared by the parser RTL.
// Depends on nothing; included by the top level.
`ifndef CDP_TLV_FRAME_PARSER_CORE_MACROS_SVH
`define CDP_TLV_FRAME_PARSER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CDP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CDP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/cdp_pkg.sv =====
// Types and constants for the discovery-frame TLV parser.
// Depends on nothing.
`timescale 1ns / 1ps
package cdp_pkg;
   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_TLVHDR, PH_VALUE, PH_SKIP
   } phase_type;
   typedef enum logic [2:0] {
      AP_COUNT, AP_PTYPE, AP_PLEN, AP_PBYTES, AP_ALEN_HI, AP_ALEN_LO, AP_ABYTES, AP_DONE
   } addr_phase_type;
   localparam logic [1:0] KIND_RECORD  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;
   localparam logic [2:0] ST_OK = 3'd0, ST_SHORT = 3'd1, ST_BADLEN = 3'd2,
                          ST_TRUNC = 3'd3, ST_CAPPED = 3'd4;
   localparam logic [15:0] TYPE_ADDRS = 16'h0002;
   localparam logic [15:0] TYPE_MGMT  = 16'h0016;
   localparam logic [15:0] EXT_LOW    = 16'h1000;
   localparam logic [15:0] EXT_HIGH   = 16'h100D;
   localparam logic [7:0]  NLPID_IP   = 8'hCC;
   localparam logic [7:0]  DEFAULT_CAP = 8'd50;
   localparam logic [31:0] LISTED_MASK = 32'hAFFFCFFE;
   localparam logic [0:0]  CSR_MAX_OBJECTS = 1'b0;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_start;
      logic [11:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [15:0] tlv_type;
      logic [15:0] tlv_length;
      logic [3:0]  value_class;
      logic [31:0] numeric_value;
      logic        is_ipv4;
      logic [1:0]  type_known;
      logic [7:0]  frame_version;
      logic [7:0]  ttl_seconds;
      logic [15:0] header_checksum;
      logic [2:0]  frame_status;
      logic        last_of_run;
   } rsp_type;

   // Up to three results per byte, in order: entry, record, summary.
   typedef struct packed {
      logic [2:0] valid;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } burst_type;
endpackage

// ===== src/cdp_if.sv =====
// Valid/ready stream interface carrying one parser item.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
interface cdp_req_if;
   logic             valid;
   logic             ready;
   cdp_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cdp_rsp_if;
   logic             valid;
   logic             ready;
   cdp_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/cdp_tlv_frame_parser_core.sv =====
// Top level of the discovery-frame TLV parser: stream ports, CSR, output queue.
// Depends on cdp_pkg, cdp_if, cdp_step and the assertion macro header.
`timescale 1ns / 1ps
`include "cdp_tlv_frame_parser_core_macros.svh"
// The parser takes one frame byte per cycle while no results are pending, and answers in the
// same pass: each accepted byte goes through one combinational step into a three-slot result
// register (up to a record entry, a record and a frame summary). The slots drain one result per
// cycle on rsp while rsp is ready, and req is held off while any result is still pending. The
// sole register, max_objects (address 0), caps records and address entries; zero acts as 50.
module cdp_tlv_frame_parser_core #(
   parameter int MAX_FRAME = 2048
) (
   input  logic        clock,
   input  logic        reset,
   cdp_req_if.sink     req,
   cdp_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] maxobj_ff;
   cdp_pkg::burst_type burst, slots_ff, slots_in;
   logic step_en, busy;
   logic [2:0] pend_ff, pend_in;

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, maxobj_ff};
   always_ff @(posedge clock) begin
      if (reset) maxobj_ff <= cdp_pkg::DEFAULT_CAP;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == cdp_pkg::CSR_MAX_OBJECTS)
         maxobj_ff <= csr_pwdata[7:0];
   end

   // pending mask drains lowest slot first; accept when last pending result leaves
   logic [2:0] after_pop;
   always_comb begin
      after_pop = pend_ff;
      if (rsp.valid && rsp.ready) begin
         if (pend_ff[0]) after_pop[0] = 1'b0;
         else if (pend_ff[1]) after_pop[1] = 1'b0;
         else after_pop[2] = 1'b0;
      end
   end
   assign busy = (after_pop != 3'd0);
   assign req.ready = !busy;
   assign step_en = req.valid && req.ready;

   cdp_step #(.MAX_FRAME(MAX_FRAME)) u_step (
      .clock(clock), .reset(reset), .step_en(step_en), .req(req.payload),
      .max_objects(maxobj_ff), .burst(burst)
   );

   always_comb begin
      slots_in = slots_ff;
      pend_in = after_pop;
      if (step_en) begin
         slots_in = burst;
         pend_in = burst.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else pend_ff <= pend_in;
      slots_ff <= slots_in;
   end

   assign rsp.valid = (pend_ff != 3'd0);
   assign rsp.payload = pend_ff[0] ? slots_ff.r0 : (pend_ff[1] ? slots_ff.r1 : slots_ff.r2);

   `CDP_ASSERT_IMP(a_no_accept_while_pending, clock, reset, step_en, after_pop == 3'd0, "accept while results pending")
   `CDP_ASSERT_NXT(a_summary_last, clock, reset, rsp.valid && pend_ff[2], rsp.valid || !pend_ff[2] || !$past(rsp.ready), "summary lost")
   `CDP_ASSERT_IMP(a_last_flag, clock, reset, rsp.valid && pend_ff == 3'b100, rsp.payload.last_of_run, "last result not marked")
endmodule

// ===== src/cdp_step.sv =====
// Per-byte parse step: frame state in, next state and result burst out.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
module cdp_step #(
   parameter int MAX_FRAME = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  cdp_pkg::req_type        req,
   input  logic [7:0]              max_objects,
   output cdp_pkg::burst_type      burst
);
   localparam int FW = 16;
   localparam logic [FW-1:0] MAX_FRAME_W = FW'(MAX_FRAME);

   cdp_pkg::phase_type      phase_ff, phase_in;
   cdp_pkg::addr_phase_type ap_ff, ap_in;
   logic [FW-1:0] pos_ff, pos_in, total_ff, total_in;
   logic [15:0] rtype_ff, rtype_in, rlen_ff, rlen_in, vrem_ff, vrem_in;
   logic [31:0] acc_ff, acc_in, decl_ff, decl_in, hdr_ff, hdr_in;
   logic [7:0]  rdone_ff, rdone_in, ent_ff, ent_in, alist_ff, alist_in, mlist_ff, mlist_in;
   logic [7:0]  ptype_ff, ptype_in, plen_ff, plen_in, pfirst_ff, pfirst_in;
   logic [15:0] alen_ff, alen_in, eleft_ff, eleft_in;
   logic [2:0]  st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cdp_pkg::PH_IDLE; ap_ff <= cdp_pkg::AP_COUNT;
         pos_ff <= '0; total_ff <= '0; rtype_ff <= '0; rlen_ff <= '0; vrem_ff <= '0;
         acc_ff <= '0; decl_ff <= '0; hdr_ff <= '0; rdone_ff <= '0; ent_ff <= '0;
         alist_ff <= '0; mlist_ff <= '0; ptype_ff <= '0; plen_ff <= '0; pfirst_ff <= '0;
         alen_ff <= '0; eleft_ff <= '0; st_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in; ap_ff <= ap_in;
         pos_ff <= pos_in; total_ff <= total_in; rtype_ff <= rtype_in; rlen_ff <= rlen_in;
         vrem_ff <= vrem_in; acc_ff <= acc_in; decl_ff <= decl_in; hdr_ff <= hdr_in;
         rdone_ff <= rdone_in; ent_ff <= ent_in; alist_ff <= alist_in; mlist_ff <= mlist_in;
         ptype_ff <= ptype_in; plen_ff <= plen_in; pfirst_ff <= pfirst_in;
         alen_ff <= alen_in; eleft_ff <= eleft_in; st_ff <= st_in;
      end
   end

   function automatic logic [1:0] known_of(input logic [15:0] t);
      if (t < 16'd32 && LISTED_BIT(t[4:0])) return 2'd1;
      if (t >= cdp_pkg::EXT_LOW && t <= cdp_pkg::EXT_HIGH) return 2'd2;
      return 2'd0;
   endfunction
   function automatic logic LISTED_BIT(input logic [4:0] i);
      return cdp_pkg::LISTED_MASK[i];
   endfunction

   always_comb begin
      logic [7:0]  b, cap;
      logic [FW-1:0] flen, rem;
      logic [15:0] vl, idx, alen_c;
      logic        is_addr, rec_fin, ent_fin, ent_put, ip4, sum, do_next;
      logic [3:0]  cls;
      logic [31:0] num;
      cdp_pkg::rsp_type rr, re, rs;
      logic [2:0]  kinds;

      b = req.frame_byte;
      cap = (max_objects == 8'd0) ? cdp_pkg::DEFAULT_CAP : max_objects;
      phase_in = phase_ff; ap_in = ap_ff; pos_in = pos_ff; total_in = total_ff;
      rtype_in = rtype_ff; rlen_in = rlen_ff; vrem_in = vrem_ff; acc_in = acc_ff;
      decl_in = decl_ff; hdr_in = hdr_ff; rdone_in = rdone_ff; ent_in = ent_ff;
      alist_in = alist_ff; mlist_in = mlist_ff; ptype_in = ptype_ff; plen_in = plen_ff;
      pfirst_in = pfirst_ff; alen_in = alen_ff; eleft_in = eleft_ff; st_in = st_ff;
      rec_fin = 1'b0; ent_fin = 1'b0; ent_put = 1'b0; sum = 1'b0; do_next = 1'b0;
      alen_c = alen_ff; vl = '0; idx = '0;

      if (req.frame_start) begin
         flen = FW'(req.frame_length);
         total_in = (flen > MAX_FRAME_W) ? MAX_FRAME_W : flen;
         if (total_in == '0) total_in = FW'(1);
         pos_in = '0; rtype_in = '0; rlen_in = '0; vrem_in = '0; acc_in = '0;
         rdone_in = '0; ap_in = cdp_pkg::AP_COUNT; decl_in = '0; ent_in = '0;
         alist_in = '0; mlist_in = '0; ptype_in = '0; plen_in = '0; pfirst_in = '0;
         alen_in = '0; eleft_in = '0; st_in = cdp_pkg::ST_OK; hdr_in = '0;
         phase_in = cdp_pkg::PH_HEADER;
         if (total_in < FW'(4)) begin
            st_in = cdp_pkg::ST_SHORT; phase_in = cdp_pkg::PH_SKIP;
         end
      end
      rem = total_in - pos_in - FW'(1);
      is_addr = (rtype_in == cdp_pkg::TYPE_ADDRS) || (rtype_in == cdp_pkg::TYPE_MGMT);

      case (phase_in)
         cdp_pkg::PH_HEADER: begin
            hdr_in = {hdr_in[23:0], b};
            if (pos_in == FW'(3)) do_next = 1'b1;
         end
         cdp_pkg::PH_TLVHDR: begin
            idx = vrem_in;
            if (idx < 16'd2) rtype_in = {rtype_in[7:0], b};
            else rlen_in = {rlen_in[7:0], b};
            vrem_in = idx + 16'd1;
            if (idx == 16'd3) begin
               vl = rlen_in - 16'd4;
               if (rlen_in < 16'd4) begin
                  st_in = cdp_pkg::ST_BADLEN; phase_in = cdp_pkg::PH_SKIP;
               end else if (FW'(vl) > rem) begin
                  st_in = cdp_pkg::ST_TRUNC; phase_in = cdp_pkg::PH_SKIP;
               end else begin
                  vrem_in = vl; acc_in = '0; decl_in = '0; ent_in = '0;
                  ap_in = (vl >= 16'd4) ? cdp_pkg::AP_COUNT : cdp_pkg::AP_DONE;
                  if (vl == 16'd0) rec_fin = 1'b1;
                  else phase_in = cdp_pkg::PH_VALUE;
               end
            end
         end
         cdp_pkg::PH_VALUE: begin
            vrem_in = vrem_in - 16'd1;
            if (is_addr) begin
               idx = (rlen_in - 16'd4) - vrem_in - 16'd1;
               case (ap_in)
                  cdp_pkg::AP_COUNT: begin
                     decl_in = {decl_in[23:0], b};
                     if (idx == 16'd3) begin
                        if (ent_in < cap && {24'd0, ent_in} < decl_in && vrem_in >= 16'd2)
                           ap_in = cdp_pkg::AP_PTYPE;
                        else ap_in = cdp_pkg::AP_DONE;
                     end
                  end
                  cdp_pkg::AP_PTYPE: begin
                     ptype_in = b; pfirst_in = '0; ap_in = cdp_pkg::AP_PLEN;
                  end
                  cdp_pkg::AP_PLEN: begin
                     plen_in = b;
                     if (vrem_in < {8'd0, b}) ap_in = cdp_pkg::AP_DONE;
                     else if (b == 8'd0)
                        ap_in = (vrem_in >= 16'd2) ? cdp_pkg::AP_ALEN_HI : cdp_pkg::AP_DONE;
                     else begin
                        eleft_in = {8'd0, b}; ap_in = cdp_pkg::AP_PBYTES;
                     end
                  end
                  cdp_pkg::AP_PBYTES: begin
                     if (eleft_in == {8'd0, plen_in}) pfirst_in = b;
                     eleft_in = eleft_in - 16'd1;
                     if (eleft_in == 16'd0)
                        ap_in = (vrem_in >= 16'd2) ? cdp_pkg::AP_ALEN_HI : cdp_pkg::AP_DONE;
                  end
                  cdp_pkg::AP_ALEN_HI: begin
                     alen_in = {b, 8'd0}; ap_in = cdp_pkg::AP_ALEN_LO;
                  end
                  cdp_pkg::AP_ALEN_LO: begin
                     alen_in = {alen_in[15:8], b}; acc_in = '0;
                     if (vrem_in < alen_in) ap_in = cdp_pkg::AP_DONE;
                     else if (alen_in == 16'd0) ent_fin = 1'b1;
                     else begin
                        eleft_in = alen_in; ap_in = cdp_pkg::AP_ABYTES;
                     end
                  end
                  cdp_pkg::AP_ABYTES: begin
                     acc_in = {acc_in[23:0], b};
                     eleft_in = eleft_in - 16'd1;
                     if (eleft_in == 16'd0) ent_fin = 1'b1;
                  end
                  default: ;
               endcase
            end else begin
               acc_in = {acc_in[23:0], b};
            end
            if (vrem_in == 16'd0) rec_fin = 1'b1;
         end
         default: ;
      endcase

      // entry completion
      ip4 = (ptype_in == 8'd1) && (plen_in == 8'd1) && (pfirst_in == cdp_pkg::NLPID_IP)
            && (alen_in == 16'd4);
      re = '0;
      if (ent_fin) begin
         ent_in = ent_in + 8'd1;
         if (rtype_in == cdp_pkg::TYPE_ADDRS) begin
            if (alist_in < cap) begin
               alist_in = alist_in + 8'd1; ent_put = 1'b1;
            end
         end else if (mlist_in < cap) begin
            mlist_in = mlist_in + 8'd1; ent_put = 1'b1;
         end
         if (ent_in < cap && {24'd0, ent_in} < decl_in && vrem_in >= 16'd2)
            ap_in = cdp_pkg::AP_PTYPE;
         else ap_in = cdp_pkg::AP_DONE;
         re.record_kind = cdp_pkg::KIND_ENTRY;
         re.tlv_type = {8'd0, ptype_in};
         re.tlv_length = alen_in;
         re.value_class = (rtype_in == cdp_pkg::TYPE_ADDRS) ? 4'd7 : 4'd8;
         re.numeric_value = ip4 ? acc_in : 32'd0;
         re.is_ipv4 = ip4;
         re.type_known = 2'd1;
      end

      // record completion
      rr = '0;
      if (rec_fin) begin
         vl = rlen_in - 16'd4; cls = 4'd9; num = '0;
         case (rtype_in)
            16'h0001, 16'h0003, 16'h0005, 16'h0006, 16'h0009, 16'h0014: cls = 4'd0;
            16'h0004: if (vl == 16'd4) begin cls = 4'd1; num = acc_in; end
            16'h000A: if (vl == 16'd2) begin cls = 4'd2; num = {16'd0, acc_in[15:0]}; end
            16'h000B: if (vl == 16'd1) begin cls = 4'd3; num = {31'd0, acc_in != 32'd0}; end
            16'h0010: if (vl == 16'd2) begin cls = 4'd4; num = {16'd0, acc_in[15:0]}; end
            16'h0019: if (vl == 16'd4) begin cls = 4'd5; num = acc_in; end
            16'h001A: if (vl == 16'd4) begin cls = 4'd6; num = acc_in; end
            cdp_pkg::TYPE_ADDRS: cls = 4'd7;
            cdp_pkg::TYPE_MGMT: cls = 4'd8;
            default: ;
         endcase
         rr.record_kind = cdp_pkg::KIND_RECORD;
         rr.tlv_type = rtype_in; rr.tlv_length = rlen_in; rr.value_class = cls;
         rr.numeric_value = num; rr.type_known = known_of(rtype_in);
         rdone_in = rdone_in + 8'd1;
         do_next = 1'b1;
      end

      if (do_next) begin
         if (rdone_in >= cap) begin
            if (rem > '0) st_in = cdp_pkg::ST_CAPPED;
            phase_in = cdp_pkg::PH_SKIP;
         end else if (rem < FW'(4)) begin
            phase_in = cdp_pkg::PH_SKIP;
         end else begin
            phase_in = cdp_pkg::PH_TLVHDR; vrem_in = '0; rtype_in = '0; rlen_in = '0;
         end
      end

      // header fields come from the state after this byte
      rs = '0;
      if (phase_ff != cdp_pkg::PH_IDLE || req.frame_start) begin
         pos_in = pos_in + FW'(1);
         if (pos_in >= total_in) begin
            sum = 1'b1; phase_in = cdp_pkg::PH_IDLE;
            rs.record_kind = cdp_pkg::KIND_SUMMARY; rs.frame_status = st_in;
         end
      end
      re.frame_version = hdr_in[31:24]; re.ttl_seconds = hdr_in[23:16];
      re.header_checksum = hdr_in[15:0];
      rr.frame_version = hdr_in[31:24]; rr.ttl_seconds = hdr_in[23:16];
      rr.header_checksum = hdr_in[15:0];
      rs.frame_version = hdr_in[31:24]; rs.ttl_seconds = hdr_in[23:16];
      rs.header_checksum = hdr_in[15:0];

      kinds = {sum, rec_fin, ent_put};
      if (ent_put && !rec_fin && !sum) re.last_of_run = 1'b1;
      if (rec_fin && !sum) rr.last_of_run = 1'b1;
      rs.last_of_run = 1'b1;
      burst.valid = kinds;
      burst.r0 = re; burst.r1 = rr; burst.r2 = rs;
   end
endmodule
